### hw/rtl/rvg_pkg.sv
// Shared types and constants of the radial vignetting gain block.
package rvg_pkg;

  // Field widths.
  localparam int unsigned DimW   = 13;
  localparam int unsigned PosW   = 12;
  localparam int unsigned ChW    = 16;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned StrW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Radius path widths.
  localparam int unsigned DeltaW = DimW + 2;         // signed doubled offset
  localparam int unsigned NumW   = 2 * DimW + 1;     // dx^2 + dy^2
  localparam int unsigned DenW   = 2 * DimW + 1;     // w^2 + h^2
  localparam int unsigned R2RemW = NumW + 16;        // num << 16
  localparam int unsigned R2Bits = 21;               // quotient bits 20..0
  localparam int unsigned R2CmpW = DenW + R2Bits;
  localparam int unsigned R2W    = 21;               // Q5.16 up to 16.0
  localparam int unsigned R4W    = 25;
  localparam int unsigned ScW    = CoefW + StrW + 1; // coefficient * strength
  localparam int unsigned T1W    = ScW + R2W + 1;
  localparam int unsigned T2W    = ScW + R4W + 1;
  localparam int unsigned FsumW  = T2W + 1;
  localparam int unsigned FallW  = 37;

  // Gain path widths.
  localparam int unsigned ChScW  = 24;               // channel * 200
  localparam int unsigned GRemW  = ChScW + 31;       // (c*200 << 30) + F
  localparam int unsigned GDenW  = FallW + 1;        // 2F
  localparam int unsigned GBits  = 19;               // quotient bits 18..0
  localparam int unsigned GCmpW  = GDenW + GBits - 1;

  localparam logic [R2W-1:0]   R2_CAP      = R2W'(1) << 20;
  localparam logic [FallW-1:0] FALLOFF_ONE = FallW'(100) << 30;
  localparam logic [FallW-1:0] FALLOFF_LOW = FallW'(15) << 30;
  localparam logic [ChScW-1:0] GAIN_SCALE  = ChScW'(200);
  localparam logic [ChW-1:0]   CH_MAX      = '1;

  localparam logic [DimW-1:0]  WIDTH_RST    = DimW'(1920);
  localparam logic [DimW-1:0]  HEIGHT_RST   = DimW'(1080);
  localparam logic [StrW-1:0]  STRENGTH_RST = StrW'(100);

  // Pipeline stage positions.
  localparam int unsigned ST_DXY   = 0;
  localparam int unsigned ST_NUM   = 1;
  localparam int unsigned ST_PRE   = 2;
  localparam int unsigned ST_R2DIV = 3;
  localparam int unsigned ST_R2CAP = ST_R2DIV + R2Bits;
  localparam int unsigned ST_R4    = ST_R2CAP + 1;
  localparam int unsigned ST_TERM  = ST_R4 + 1;
  localparam int unsigned ST_FALL  = ST_TERM + 1;
  localparam int unsigned ST_GNUM  = ST_FALL + 1;
  localparam int unsigned ST_GDIV  = ST_GNUM + 1;
  localparam int unsigned ST_OUT   = ST_GDIV + GBits;
  localparam int unsigned NumSt    = ST_OUT + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COEF_QUAD    = 3'd2,
    CFG_COEF_QUART   = 3'd3,
    CFG_STRENGTH     = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [ChW-1:0] alpha;
    logic [ChW-1:0] blue;
    logic [ChW-1:0] green;
    logic [ChW-1:0] red;
  } side_t;

endpackage

### hw/rtl/radial_vignetting_gain_top.sv
// Radial vignetting gain: pixel pipeline with radius and gain dividers.
// Pipeline: 49 register stages from input to output.
// One word per cycle unless stalled; a stall holds the run of full stages at the output.
// The radius divider spends 21 stages and the gain dividers 19, one bit each.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module radial_vignetting_gain_top
  import rvg_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pixel_col, pixel_row, red_in, green_in, blue_in, alpha_in
  input  logic [87:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [63:0]         m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ClampW = DimW + 2;

  // ---------------- configuration ----------------
  logic [DimW-1:0]         width_q, height_q;
  logic signed [CoefW-1:0] cq_q, ck_q;
  logic [StrW-1:0]         str_q;
  logic [DenW-1:0]         den_q;
  logic signed [ScW-1:0]   qs_q, ks_q;

  function automatic logic [DimW-1:0] fit_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if ({2'b00, v} > ClampW'(MAX_DIM)) begin
      r = DimW'(MAX_DIM);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      cq_q     <= '0;
      ck_q     <= '0;
      str_q    <= STRENGTH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  width_q  <= fit_dim(cfg_data_i[DimW-1:0]);
        CFG_FRAME_HEIGHT: height_q <= fit_dim(cfg_data_i[DimW-1:0]);
        CFG_COEF_QUAD:    cq_q     <= $signed(cfg_data_i);
        CFG_COEF_QUART:   ck_q     <= $signed(cfg_data_i);
        CFG_STRENGTH:     str_q    <= cfg_data_i[StrW-1:0];
        default: ;
      endcase
    end
  end

  // Terms that follow the registers alone; they are registered, so they lag a register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q <= '0;
      qs_q  <= '0;
      ks_q  <= '0;
    end else begin
      den_q <= DenW'(width_q * width_q) + DenW'(height_q * height_q);
      qs_q  <= ScW'(cq_q * $signed({1'b0, str_q}));
      ks_q  <= ScW'(ck_q * $signed({1'b0, str_q}));
    end
  end

  // ---------------- flow control ----------------
  logic [NumSt-1:0] v_q;
  logic [NumSt-1:0] adv;
  side_t            side_q [NumSt];

  for (genvar i = 0; i < NumSt; i++) begin : g_adv
    if (i == NumSt - 1) begin : g_last
      assign adv[i] = !v_q[i] || m_axis_tready;
    end else begin : g_mid
      assign adv[i] = !v_q[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NumSt; i++) begin
        if (adv[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= side_t'({s_axis_tdata[87:72], s_axis_tdata[71:56],
                            s_axis_tdata[55:40], s_axis_tdata[39:24]});
    end
    for (int i = 1; i < NumSt; i++) begin
      if (adv[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------- radius ----------------
  logic signed [DeltaW-1:0] dx_q, dy_q;
  logic [NumW-1:0]          num_q;
  logic signed [2*DeltaW-1:0] dxsq, dysq;
  logic [PosW-1:0]          col_in, row_in;

  assign col_in = s_axis_tdata[11:0];
  assign row_in = s_axis_tdata[23:12];
  assign dxsq   = dx_q * dx_q;
  assign dysq   = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (adv[ST_DXY]) begin
      dx_q <= $signed({2'b00, col_in, 1'b0}) - $signed({2'b00, width_q});
      dy_q <= $signed({2'b00, row_in, 1'b0}) - $signed({2'b00, height_q});
    end
    if (adv[ST_NUM]) begin
      num_q <= NumW'(dxsq) + NumW'(dysq);
    end
  end

  // r2 = floor((num << 16) / den), one quotient bit per stage
  logic [R2RemW-1:0] r2_rem_q [R2Bits+1];
  logic [R2Bits-1:0] r2_quo_q [R2Bits+1];
  logic              r2_sat_q [R2Bits+1];

  always_ff @(posedge clk_i) begin
    if (adv[ST_PRE]) begin
      r2_rem_q[0] <= {num_q, 16'b0};
      r2_quo_q[0] <= '0;
      r2_sat_q[0] <= {5'b0, num_q} >= {den_q, 5'b0};
    end
  end

  for (genvar k = 1; k <= R2Bits; k++) begin : g_r2div
    localparam int unsigned Bit = R2Bits - k;
    logic [R2CmpW-1:0] dsh;
    logic              take;
    assign dsh  = R2CmpW'(den_q) << Bit;
    assign take = R2CmpW'(r2_rem_q[k-1]) >= dsh;
    always_ff @(posedge clk_i) begin
      if (adv[ST_R2DIV+k-1]) begin
        r2_rem_q[k] <= take ? R2RemW'(R2CmpW'(r2_rem_q[k-1]) - dsh) : r2_rem_q[k-1];
        r2_quo_q[k] <= r2_quo_q[k-1] | (take ? (R2Bits'(1) << Bit) : '0);
        r2_sat_q[k] <= r2_sat_q[k-1];
      end
    end
  end

  // ---------------- falloff ----------------
  logic [R2W-1:0]          r2_q, r2b_q;
  logic [R4W-1:0]          r4_q;
  logic [2*R2W-1:0]        r2sq;
  logic signed [T1W-1:0]   t1_d, t1_q;
  logic signed [T2W-1:0]   t2_d, t2_q;
  logic signed [FsumW-1:0] fsum;
  logic [FallW-1:0]        fall_q;

  assign r2sq = r2_q * r2_q;
  assign t1_d = qs_q * $signed({1'b0, r2b_q});
  assign t2_d = ks_q * $signed({1'b0, r4_q});
  assign fsum = $signed(FsumW'(FALLOFF_ONE)) + FsumW'(t1_q) + FsumW'(t2_q);

  always_ff @(posedge clk_i) begin
    if (adv[ST_R2CAP]) begin
      r2_q <= (r2_sat_q[R2Bits] || r2_quo_q[R2Bits] > R2_CAP) ? R2_CAP
                                                               : r2_quo_q[R2Bits];
    end
    if (adv[ST_R4]) begin
      r2b_q <= r2_q;
      r4_q  <= R4W'(r2sq >> 16);
    end
    if (adv[ST_TERM]) begin
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
    if (adv[ST_FALL]) begin
      if (fsum < $signed(FsumW'(FALLOFF_LOW))) begin
        fall_q <= FALLOFF_LOW;
      end else if (fsum > $signed(FsumW'(FALLOFF_ONE))) begin
        fall_q <= FALLOFF_ONE;
      end else begin
        fall_q <= FallW'(fsum);
      end
    end
  end

  // ---------------- gain ----------------
  // out = floor((c*200*2^30 + F) / 2F), one quotient bit per stage
  logic [GRemW-1:0] g_rem_q [GBits+1][3];
  logic [GBits-1:0] g_quo_q [GBits+1][3];
  logic [GDenW-1:0] g_den_q [GBits+1];
  logic [ChW-1:0]   ch_at_gnum [3];
  logic [ChW-1:0]   out_ch_q [3];

  assign ch_at_gnum[0] = side_q[ST_GNUM-1].red;
  assign ch_at_gnum[1] = side_q[ST_GNUM-1].green;
  assign ch_at_gnum[2] = side_q[ST_GNUM-1].blue;

  always_ff @(posedge clk_i) begin
    if (adv[ST_GNUM]) begin
      g_den_q[0] <= {fall_q, 1'b0};
      for (int c = 0; c < 3; c++) begin
        g_rem_q[0][c] <= {1'b0, ChScW'(ch_at_gnum[c]) * GAIN_SCALE, 30'b0}
                         + GRemW'(fall_q);
        g_quo_q[0][c] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= GBits; k++) begin : g_gdiv
    localparam int unsigned Bit = GBits - k;
    logic [GCmpW-1:0] dsh;
    assign dsh = GCmpW'(g_den_q[k-1]) << Bit;
    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic take;
      assign take = GCmpW'(g_rem_q[k-1][c]) >= dsh;
      always_ff @(posedge clk_i) begin
        if (adv[ST_GDIV+k-1]) begin
          g_rem_q[k][c] <= take ? GRemW'(GCmpW'(g_rem_q[k-1][c]) - dsh)
                                : g_rem_q[k-1][c];
          g_quo_q[k][c] <= g_quo_q[k-1][c] | (take ? (GBits'(1) << Bit) : '0);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[ST_GDIV+k-1]) begin
        g_den_q[k] <= g_den_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      for (int c = 0; c < 3; c++) begin
        out_ch_q[c] <= (g_quo_q[GBits][c] > GBits'(CH_MAX)) ? CH_MAX
                                                            : ChW'(g_quo_q[GBits][c]);
      end
    end
  end

  assign m_axis_tvalid = v_q[ST_OUT];
  assign m_axis_tdata  = {side_q[ST_OUT].alpha, out_ch_q[2], out_ch_q[1], out_ch_q[0]};

  // ---------------- checks ----------------
  a_r2_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_R2CAP-1] && !r2_sat_q[R2Bits]) |-> (R2CmpW'(r2_rem_q[R2Bits]) < R2CmpW'(den_q)))
    else $error("radius divider remainder not below denominator");

  a_r2_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_R2CAP] |-> (r2_q <= R2_CAP))
    else $error("radius above cap");

  a_fall_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_FALL] |-> (fall_q >= FALLOFF_LOW && fall_q <= FALLOFF_ONE))
    else $error("falloff outside clamp range");

  a_gain_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_OUT-1] |-> (GCmpW'(g_rem_q[GBits][0]) < GCmpW'(g_den_q[GBits])))
    else $error("gain divider remainder not below divisor");

  a_gain_not_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_OUT] |-> (out_ch_q[0] >= side_q[ST_OUT].red
                     && out_ch_q[1] >= side_q[ST_OUT].green
                     && out_ch_q[2] >= side_q[ST_OUT].blue))
    else $error("corrected channel below its input");

endmodule
